/* rtl/qft_pkg.sv */
// Shared constants and codes for the quaternion frame transform core.
// No dependencies.
`default_nettype none

package qft_pkg;

   localparam int COORD_WIDTH_DEFAULT    = 32;
   localparam int QUAT_FRAC_BITS_DEFAULT = 30;
   localparam int CSR_INDEX_WIDTH        = 3;

   typedef enum logic [1:0] {
      KIND_POINT_PARENT = 2'd0,
      KIND_POINT_LOCAL  = 2'd1,
      KIND_DIR_PARENT   = 2'd2,
      KIND_DIR_LOCAL    = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROT_W    = 3'd0,
      CSR_ROT_X    = 3'd1,
      CSR_ROT_Y    = 3'd2,
      CSR_ROT_Z    = 3'd3,
      CSR_OFFSET_X = 3'd4,
      CSR_OFFSET_Y = 3'd5,
      CSR_OFFSET_Z = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

/* rtl/quaternion_frame_transform_core.sv */
// Quaternion rigid transform of Q16.16 3-vectors, five-stage pipeline.
// Depends on qft_pkg.
`default_nettype none

// Applies the pose in the csr registers (unit quaternion in Q2.30, translation in
// Q16.16) to each request word: kind selects point or direction, to parent or to
// local frame. One word is accepted per cycle while req_stall is low. The rotation
// matrix is rebuilt for each word in stages 1 and 2 (nine quaternion products, then
// rounding), stage 3 holds the nine matrix-by-coordinate products, stage 4 the sums,
// stage 5 the rounded, offset and saturated result. req_stall rises only when all five
// stages hold words and the output is stalled. Write the csr registers only while no
// word is in flight.
module quaternion_frame_transform_core #(
   parameter int COORD_WIDTH    = qft_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUAT_FRAC_BITS = qft_pkg::QUAT_FRAC_BITS_DEFAULT,
   localparam int QB            = QUAT_FRAC_BITS + 2,
   localparam int CSR_DATA_WIDTH = (QB > COORD_WIDTH) ? QB : COORD_WIDTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [1:0]                              req_kind,
   input  wire logic signed [COORD_WIDTH-1:0]           req_vec_x,
   input  wire logic signed [COORD_WIDTH-1:0]           req_vec_y,
   input  wire logic signed [COORD_WIDTH-1:0]           req_vec_z,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [COORD_WIDTH-1:0]                rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]                rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]                rsp_out_z,
   output logic                                         rsp_saturated,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [qft_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]               csr_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int QF  = QUAT_FRAC_BITS;
   localparam int PW  = 2 * QB;          // quaternion product
   localparam int MW  = QF + 6;          // matrix entry
   localparam int DW  = CW + 1;          // vector after optional v - t
   localparam int PRW = MW + DW;         // matrix-by-coordinate product
   localparam int AW  = PRW + 2;         // sum of three products
   localparam int SW  = AW - QF + 1;     // rounded sum plus offset

   localparam int P_XX = 0;
   localparam int P_YY = 1;
   localparam int P_ZZ = 2;
   localparam int P_XY = 3;
   localparam int P_XZ = 4;
   localparam int P_YZ = 5;
   localparam int P_WX = 6;
   localparam int P_WY = 7;
   localparam int P_WZ = 8;

   localparam logic signed [QB-1:0]  ONE_Q  = {{(QB-QF-1){1'b0}}, 1'b1, {QF{1'b0}}};
   localparam logic signed [MW-1:0]  ONE_M  = {{(MW-QF-1){1'b0}}, 1'b1, {QF{1'b0}}};
   localparam logic signed [PW:0]    HALF_M = {{(PW-QF+2){1'b0}}, 1'b1, {(QF-2){1'b0}}};
   localparam logic signed [AW-1:0]  HALF_A = {{(AW-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
   localparam logic signed [SW-1:0]  SAT_MAX = SW'({1'b0, {(CW-1){1'b1}}});
   localparam logic signed [SW-1:0]  SAT_MIN = -SAT_MAX - SW'(1);
   localparam logic signed [CW-1:0]  OUT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0]  OUT_MIN = {1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [MW-1:0] twice_rnd(input logic signed [PW-1:0] p,
                                                      input logic signed [PW-1:0] q,
                                                      input logic sub);
      logic signed [PW:0] s;
      s = sub ? ((PW+1)'(p) - (PW+1)'(q)) : ((PW+1)'(p) + (PW+1)'(q));
      s = s + HALF_M;
      return MW'(s >>> (QF - 1));
   endfunction

   // csr registers
   logic signed [QB-1:0] rot_ff [4];
   logic signed [CW-1:0] ofs_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ONE_Q;
         rot_ff[1] <= '0;
         rot_ff[2] <= '0;
         rot_ff[3] <= '0;
         ofs_ff[0] <= '0;
         ofs_ff[1] <= '0;
         ofs_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            qft_pkg::CSR_ROT_W:    rot_ff[0] <= csr_data[QB-1:0];
            qft_pkg::CSR_ROT_X:    rot_ff[1] <= csr_data[QB-1:0];
            qft_pkg::CSR_ROT_Y:    rot_ff[2] <= csr_data[QB-1:0];
            qft_pkg::CSR_ROT_Z:    rot_ff[3] <= csr_data[QB-1:0];
            qft_pkg::CSR_OFFSET_X: ofs_ff[0] <= csr_data[CW-1:0];
            qft_pkg::CSR_OFFSET_Y: ofs_ff[1] <= csr_data[CW-1:0];
            qft_pkg::CSR_OFFSET_Z: ofs_ff[2] <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // stage enables, bubbles collapse
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !rsp_valid_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= req_valid;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) v4_ff        <= v3_ff;
         if (en5) rsp_valid_ff <= v4_ff;
      end
   end

   // stage 1: quaternion products, v or v - t
   qft_pkg::kind_type     kind_in;
   qft_pkg::kind_type     kind1_ff, kind2_ff, kind3_ff, kind4_ff;
   logic signed [CW-1:0]  vec [3];
   logic signed [PW-1:0]  pr_in [9];
   logic signed [PW-1:0]  pr_ff [9];
   logic signed [DW-1:0]  d_in  [3];
   logic signed [DW-1:0]  d1_ff [3];
   logic signed [DW-1:0]  d2_ff [3];

   assign kind_in = qft_pkg::kind_type'(req_kind);
   assign vec[0]  = req_vec_x;
   assign vec[1]  = req_vec_y;
   assign vec[2]  = req_vec_z;

   always_comb begin
      pr_in[P_XX] = PW'(rot_ff[1]) * PW'(rot_ff[1]);
      pr_in[P_YY] = PW'(rot_ff[2]) * PW'(rot_ff[2]);
      pr_in[P_ZZ] = PW'(rot_ff[3]) * PW'(rot_ff[3]);
      pr_in[P_XY] = PW'(rot_ff[1]) * PW'(rot_ff[2]);
      pr_in[P_XZ] = PW'(rot_ff[1]) * PW'(rot_ff[3]);
      pr_in[P_YZ] = PW'(rot_ff[2]) * PW'(rot_ff[3]);
      pr_in[P_WX] = PW'(rot_ff[0]) * PW'(rot_ff[1]);
      pr_in[P_WY] = PW'(rot_ff[0]) * PW'(rot_ff[2]);
      pr_in[P_WZ] = PW'(rot_ff[0]) * PW'(rot_ff[3]);
      for (int i = 0; i < 3; i++) begin
         if (kind_in == qft_pkg::KIND_POINT_LOCAL) begin
            d_in[i] = DW'(vec[i]) - DW'(ofs_ff[i]);
         end else begin
            d_in[i] = DW'(vec[i]);
         end
      end
   end

   // stage 2: rounded matrix, transposed for the local modes
   logic signed [MW-1:0] m     [3][3];
   logic signed [MW-1:0] cm_in [3][3];
   logic signed [MW-1:0] cm_ff [3][3];

   always_comb begin
      m[0][0] = ONE_M - twice_rnd(pr_ff[P_YY], pr_ff[P_ZZ], 1'b0);
      m[0][1] = twice_rnd(pr_ff[P_XY], pr_ff[P_WZ], 1'b1);
      m[0][2] = twice_rnd(pr_ff[P_XZ], pr_ff[P_WY], 1'b0);
      m[1][0] = twice_rnd(pr_ff[P_XY], pr_ff[P_WZ], 1'b0);
      m[1][1] = ONE_M - twice_rnd(pr_ff[P_XX], pr_ff[P_ZZ], 1'b0);
      m[1][2] = twice_rnd(pr_ff[P_YZ], pr_ff[P_WX], 1'b1);
      m[2][0] = twice_rnd(pr_ff[P_XZ], pr_ff[P_WY], 1'b1);
      m[2][1] = twice_rnd(pr_ff[P_YZ], pr_ff[P_WX], 1'b0);
      m[2][2] = ONE_M - twice_rnd(pr_ff[P_XX], pr_ff[P_YY], 1'b0);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (kind1_ff == qft_pkg::KIND_POINT_LOCAL ||
                kind1_ff == qft_pkg::KIND_DIR_LOCAL) begin
               cm_in[i][j] = m[j][i];
            end else begin
               cm_in[i][j] = m[i][j];
            end
         end
      end
   end

   // stage 3: matrix-by-coordinate products
   logic signed [PRW-1:0] mp_in [3][3];
   logic signed [PRW-1:0] mp_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mp_in[i][j] = PRW'(cm_ff[i][j]) * PRW'(d2_ff[j]);
         end
      end
   end

   // stage 4: row sums with rounding constant
   logic signed [AW-1:0] acc_in [3];
   logic signed [AW-1:0] acc_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = AW'(mp_ff[i][0]) + AW'(mp_ff[i][1]) + AW'(mp_ff[i][2]) + HALF_A;
      end
   end

   // stage 5: scale, offset, saturate
   logic signed [SW-1:0] res    [3];
   logic signed [CW-1:0] out_in [3];
   logic signed [CW-1:0] out_ff [3];
   logic [2:0]           clip;
   logic                 sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res[i] = SW'(acc_ff[i] >>> QF);
         if (kind4_ff == qft_pkg::KIND_POINT_PARENT) begin
            res[i] = res[i] + SW'(ofs_ff[i]);
         end
         if (res[i] > SAT_MAX) begin
            out_in[i] = OUT_MAX;
            clip[i]   = 1'b1;
         end else if (res[i] < SAT_MIN) begin
            out_in[i] = OUT_MIN;
            clip[i]   = 1'b1;
         end else begin
            out_in[i] = CW'(res[i]);
            clip[i]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         kind1_ff <= kind_in;
         pr_ff    <= pr_in;
         d1_ff    <= d_in;
      end
      if (en2) begin
         kind2_ff <= kind1_ff;
         cm_ff    <= cm_in;
         d2_ff    <= d1_ff;
      end
      if (en3) begin
         kind3_ff <= kind2_ff;
         mp_ff    <= mp_in;
      end
      if (en4) begin
         kind4_ff <= kind3_ff;
         acc_ff   <= acc_in;
      end
      if (en5) begin
         out_ff <= out_in;
         sat_ff <= |clip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_saturated = sat_ff;

   // the input stalls only on a full pipeline
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a word in the last stage reaches the output when it advances
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && en5) |=> rsp_valid_ff)
      else $error("word lost between stage 4 and output");

   // a clipped word carries a rail value
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |->
         (out_ff[0] == OUT_MAX || out_ff[0] == OUT_MIN ||
          out_ff[1] == OUT_MAX || out_ff[1] == OUT_MIN ||
          out_ff[2] == OUT_MAX || out_ff[2] == OUT_MIN))
      else $error("saturation flag without a clipped component");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !v1_ff && !v4_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
